FILE: hdl/tpls_pkg.sv
// Package for the three-point log-domain smoother.
// Holds defaults, register constants and the control beat type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpls_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CFG_WIDTH = 32;
   localparam logic [CFG_WIDTH-1:0] FLOOR_RESET = 32'h0001_0000;
   localparam int DIGIT_BITS = 3;

   typedef struct packed {
      logic valid;
      logic log_mode;
      logic last;
   } ctl_type;
endpackage
`default_nettype wire

FILE: hdl/tpls_cell.sv
// One cell of the root/quotient row: retires one cube-root bit or three quotient bits.
// Depends on tpls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpls_cell #(
   parameter int OW = 33,
   parameter int NW = 99,
   parameter int RW = 72
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tpls_pkg::ctl_type     ctl_i,
   input  wire logic [NW-1:0]         n_i,
   input  wire logic [RW-1:0]         r_i,
   input  wire logic [OW-1:0]         y_i,
   input  wire logic [2*OW-1:0]       s_i,
   input  wire logic [NW-1:0]         q_i,
   input  wire logic [tpls_pkg::CFG_WIDTH-1:0] f_i,
   output tpls_pkg::ctl_type          ctl_o,
   output logic [NW-1:0]              n_o,
   output logic [RW-1:0]              r_o,
   output logic [OW-1:0]              y_o,
   output logic [2*OW-1:0]            s_o,
   output logic [NW-1:0]              q_o,
   output logic [tpls_pkg::CFG_WIDTH-1:0] f_o
);
   import tpls_pkg::*;

   ctl_type              ctl_ff;
   logic [NW-1:0]        n_ff, n_in, q_ff, q_in;
   logic [RW-1:0]        r_ff, r_in;
   logic [OW-1:0]        y_ff, y_in;
   logic [2*OW-1:0]      s_ff, s_in;
   logic [CFG_WIDTH-1:0] f_ff;

   logic [DIGIT_BITS-1:0] dig, qd;
   logic [RW-1:0]         rt, t4, d;
   logic [4:0]            rem;
   logic                  ge;

   always_comb begin
      dig = n_i[NW-1 -: DIGIT_BITS];
      n_in = n_i << DIGIT_BITS;
      rt = {r_i[RW-DIGIT_BITS-1:0], dig};
      t4 = (RW'(s_i) << 2) + (RW'(y_i) << 1);
      d = t4 + (t4 << 1) + RW'(1);
      ge = (rt >= d);
      rem = {r_i[1:0], dig};
      qd = '0;
      for (int k = DIGIT_BITS - 1; k >= 0; k--) begin
         if (rem >= 5'(3 << k)) begin
            rem = rem - 5'(3 << k);
            qd[k] = 1'b1;
         end
      end
      if (ctl_i.log_mode) begin
         r_in = ge ? rt - d : rt;
      end else begin
         r_in = RW'(rem);
      end
      y_in = {y_i[OW-2:0], ge};
      s_in = ge ? (s_i << 2) + (2*OW)'({y_i, 2'b00}) + (2*OW)'(1) : (s_i << 2);
      q_in = {q_i[NW-DIGIT_BITS-1:0], qd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      y_ff <= y_in;
      s_ff <= s_in;
      q_ff <= q_in;
      f_ff <= f_i;
   end

   assign ctl_o = ctl_ff;
   assign n_o = n_ff;
   assign r_o = r_ff;
   assign y_o = y_ff;
   assign s_o = s_ff;
   assign q_o = q_ff;
   assign f_o = f_ff;
endmodule
`default_nettype wire

FILE: hdl/three_point_log_domain_smoother.sv
// Throughput: one beat per cycle; busy stays low, the receiver cannot stall.
// The row of root cells retires one cube-root bit or three quotient bits per cell,
// behind four operand and multiplier stages and one output register.
// Reset clears all valid flags and loads 1.0 into the floor register.
// Top level of the smoother; depends on tpls_pkg and tpls_cell.
`timescale 1ns / 1ps
`default_nettype none
module three_point_log_domain_smoother #(
   parameter int DATA_WIDTH = tpls_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS = tpls_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [DATA_WIDTH-1:0]           req_center_intensity,
   input  wire logic [DATA_WIDTH-1:0]           req_lower_intensity,
   input  wire logic [DATA_WIDTH-1:0]           req_upper_intensity,
   input  wire logic                            req_is_last,
   output logic                                 rsp_strobe,
   output logic [DATA_WIDTH-1:0]                rsp_smoothed_value,
   output logic                                 rsp_saturated,
   output logic                                 rsp_last_of_pass,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tpls_pkg::CFG_WIDTH-1:0]  csr_floor_or_ratio
);
   import tpls_pkg::*;

   localparam int OW = ((DATA_WIDTH > CFG_WIDTH) ? DATA_WIDTH : CFG_WIDTH) + 1;
   localparam int NW = DIGIT_BITS * OW;
   localparam int RW = 2 * OW + 6;
   localparam int SW = DATA_WIDTH + FRAC_BITS + CFG_WIDTH + 2;

   logic [CFG_WIDTH-1:0] cfg_ff;
   logic                 log_sel;
   logic [CFG_WIDTH-1:0] mag;

   ctl_type              ctl1_ff, ctl1_in, ctl2_ff, ctl3_ff, ctl4_ff;
   logic [CFG_WIDTH-1:0] f1_ff, f2_ff, f3_ff, f4_ff;
   logic [OW-1:0]        x1_ff, x1_in, y1_ff, y1_in, z1_ff, z1_in;
   logic [2*OW-1:0]      m2_ff, m2_in;
   logic [OW-1:0]        z2_ff;
   logic [2*OW-1:0]      plo3_ff, phi3_ff;
   logic [NW-1:0]        n3_ff, n4_ff, n4_in;
   logic [SW-1:0]        lin_sum;

   ctl_type              ch_ctl [0:OW];
   logic [NW-1:0]        ch_n [0:OW];
   logic [RW-1:0]        ch_r [0:OW];
   logic [OW-1:0]        ch_y [0:OW];
   logic [2*OW-1:0]      ch_s [0:OW];
   logic [NW-1:0]        ch_q [0:OW];
   logic [CFG_WIDTH-1:0] ch_f [0:OW];

   logic                  rsp_strobe_ff, sat_ff, sat_in, last_ff;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [OW-1:0]         root_f, res_log;
   logic [NW-1:0]         val;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= FLOOR_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= csr_floor_or_ratio;
      end
   end

   always_comb begin
      log_sel = !cfg_ff[CFG_WIDTH-1] && (cfg_ff != '0);
      mag = cfg_ff[CFG_WIDTH-1] ? (~cfg_ff + CFG_WIDTH'(1)) : '0;
      ctl1_in.valid = start && !busy;
      ctl1_in.log_mode = log_sel;
      ctl1_in.last = req_is_last;
      if (log_sel) begin
         x1_in = OW'(req_center_intensity) + OW'(cfg_ff);
         y1_in = OW'(req_lower_intensity) + OW'(cfg_ff);
         z1_in = OW'(req_upper_intensity) + OW'(cfg_ff);
      end else begin
         x1_in = OW'(req_center_intensity);
         y1_in = OW'(req_lower_intensity) + OW'(req_upper_intensity);
         z1_in = OW'(mag);
      end
      m2_in = (2*OW)'(ctl1_ff.log_mode ? x1_ff : z1_ff) * (2*OW)'(y1_ff);
      lin_sum = (SW'(z2_ff) << FRAC_BITS) + SW'(m2_ff);
      n4_in = ctl3_ff.log_mode ? NW'(plo3_ff) + (NW'(phi3_ff) << OW) : n3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      z1_ff <= z1_in;
      f1_ff <= cfg_ff;
      m2_ff <= m2_in;
      z2_ff <= ctl1_ff.log_mode ? z1_ff : x1_ff;
      f2_ff <= f1_ff;
      plo3_ff <= (2*OW)'(m2_ff[OW-1:0]) * (2*OW)'(z2_ff);
      phi3_ff <= (2*OW)'(m2_ff[2*OW-1:OW]) * (2*OW)'(z2_ff);
      n3_ff <= NW'(lin_sum >> FRAC_BITS);
      f3_ff <= f2_ff;
      n4_ff <= n4_in;
      f4_ff <= f3_ff;
   end

   assign ch_ctl[0] = ctl4_ff;
   assign ch_n[0] = n4_ff;
   assign ch_r[0] = '0;
   assign ch_y[0] = '0;
   assign ch_s[0] = '0;
   assign ch_q[0] = '0;
   assign ch_f[0] = f4_ff;

   for (genvar gi = 0; gi < OW; gi++) begin : g_cell
      tpls_cell #(
         .OW(OW),
         .NW(NW),
         .RW(RW)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl_i(ch_ctl[gi]),
         .n_i(ch_n[gi]),
         .r_i(ch_r[gi]),
         .y_i(ch_y[gi]),
         .s_i(ch_s[gi]),
         .q_i(ch_q[gi]),
         .f_i(ch_f[gi]),
         .ctl_o(ch_ctl[gi+1]),
         .n_o(ch_n[gi+1]),
         .r_o(ch_r[gi+1]),
         .y_o(ch_y[gi+1]),
         .s_o(ch_s[gi+1]),
         .q_o(ch_q[gi+1]),
         .f_o(ch_f[gi+1])
      );
   end

   always_comb begin
      root_f = OW'(ch_f[OW]);
      res_log = (ch_y[OW] > root_f) ? ch_y[OW] - root_f : '0;
      val = ch_ctl[OW].log_mode ? NW'(res_log) : ch_q[OW];
      sat_in = (val > NW'({DATA_WIDTH{1'b1}}));
      value_in = sat_in ? {DATA_WIDTH{1'b1}} : val[DATA_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ch_ctl[OW].valid;
      end
      value_ff <= value_in;
      sat_ff <= sat_in;
      last_ff <= ch_ctl[OW].last;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_smoothed_value = value_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last_of_pass = last_ff;
endmodule
`default_nettype wire

FILE: hdl/tpls_checker.sv
// Port-level checker for the smoother, bound to the top level.
// Depends on tpls_pkg and three_point_log_domain_smoother.
`timescale 1ns / 1ps
`default_nettype none
module tpls_checker #(
   parameter int DATA_WIDTH = tpls_pkg::DATA_WIDTH_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  busy,
   input wire logic                  csr_ready,
   input wire logic                  rsp_strobe,
   input wire logic                  rsp_saturated,
   input wire logic [DATA_WIDTH-1:0] rsp_smoothed_value
);
   import tpls_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |-> (rsp_smoothed_value == {DATA_WIDTH{1'b1}}))
      else $error("saturated beat without maximum value");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result beat right after reset");
endmodule

bind three_point_log_domain_smoother tpls_checker #(.DATA_WIDTH(DATA_WIDTH)) u_tpls_checker (
   .clock(clock),
   .reset(reset),
   .busy(busy),
   .csr_ready(csr_ready),
   .rsp_strobe(rsp_strobe),
   .rsp_saturated(rsp_saturated),
   .rsp_smoothed_value(rsp_smoothed_value)
);
`default_nettype wire
